// ===== design/hps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg: shared definitions for the harmonic product spectrum block
// Frame geometry, field widths, harmonic limits and the item records that
// travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package hps_pkg;

   // frame geometry
   localparam int FRAME_SIZE    = 512;
   localparam int IDX_W         = $clog2(FRAME_SIZE);

   // harmonic range
   localparam int MAX_HARMONICS = 16;
   localparam int HARM_MIN      = 2;
   localparam int HARM_RESET    = 4;
   localparam int HARM_W        = 5;
   localparam int H_W           = $clog2(MAX_HARMONICS + 1);

   // field and datapath widths
   localparam int MAG_W         = 16;
   localparam int SUM_W         = MAG_W + $clog2(MAX_HARMONICS);
   localparam int PROD_W        = 32;
   localparam int FRAC_SHIFT    = 8;
   localparam int MUL_W         = PROD_W + SUM_W;
   localparam int BIN_W         = 9;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // one classified input item
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [IDX_W-1:0] idx;
      logic             last;
   } hps_entry_type;

   // item issued from the back end to the compute engine
   typedef struct packed {
      logic          pop;
      hps_entry_type entry;
   } hps_item_type;

endpackage

// ===== design/hps_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_req_if: input channel
// Valid/ready channel carrying one spectrum bin magnitude per item.
// ----------------------------------------------------------------------------
interface hps_req_if import hps_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] bin_magnitude;

   modport source (output valid, output bin_magnitude, input ready);
   modport sink   (input valid, input bin_magnitude, output ready);

endinterface

// ===== design/hps_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_rsp_if: result channel
// Valid/ready channel carrying one harmonic product bin per item.
// ----------------------------------------------------------------------------
interface hps_rsp_if import hps_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [PROD_W-1:0] product_value;
   logic [BIN_W-1:0]  bin_index;
   logic              frame_last;

   modport source (output valid, output product_value, output bin_index,
                   output frame_last, input ready);
   modport sink   (input valid, input product_value, input bin_index,
                   input frame_last, output ready);

endinterface

// ===== design/hps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_front: input front end
// Accepts bin items, tags each with its position in the frame and marks the
// last bin, then pushes the item into the queue.
// ----------------------------------------------------------------------------
module hps_front import hps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   hps_req_if.sink       req_ch,
   input  logic          queue_full,
   output logic          push,
   output hps_entry_type push_entry
);

   logic [IDX_W-1:0] bin_ff;
   logic [IDX_W-1:0] bin_in;
   logic             is_last;

   // accept whenever the queue has room
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign is_last      = (bin_ff == IDX_W'(FRAME_SIZE - 1));

   assign push_entry.mag  = req_ch.bin_magnitude;
   assign push_entry.idx  = bin_ff;
   assign push_entry.last = is_last;

   // bin position within the frame
   always_comb begin
      bin_in = bin_ff;
      if (push) begin
         bin_in = is_last ? '0 : bin_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff <= '0;
      end else begin
         bin_ff <= bin_in;
      end
   end

endmodule

// ===== design/hps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_queue: item queue between front and back
// Small register FIFO so that the front end keeps taking items while the
// back end is busy with a frame.
// ----------------------------------------------------------------------------
module hps_queue import hps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hps_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output hps_entry_type head_entry
);

   hps_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/hps_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_engine: frame store and harmonic product engine
// Holds the input frame, the slot sums and both product banks. Once the last
// bin of a frame is written it runs one pass per harmonic: a sum sweep that
// folds bin n into slot n/h, then a multiply sweep over all bins.
// ----------------------------------------------------------------------------
module hps_engine import hps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [H_W-1:0]    harm_top,
   input  hps_item_type      item,
   output logic [PROD_W-1:0] item_data,
   output logic              busy
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SUM       = 3'd1;
   localparam logic [2:0] ST_SUM_DRAIN = 3'd2;
   localparam logic [2:0] ST_MUL       = 3'd3;
   localparam logic [2:0] ST_MUL_DRAIN = 3'd4;

   // memories
   logic [MAG_W-1:0]  frame_mem [FRAME_SIZE];
   logic [SUM_W-1:0]  sum_mem   [FRAME_SIZE];
   logic [PROD_W-1:0] prod_mem  [2][FRAME_SIZE];

   // sequencer
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [H_W-1:0]   h_ff, h_in;
   logic [H_W-1:0]   r_ff, r_in;
   logic [IDX_W-1:0] q_ff, q_in;
   logic [IDX_W-1:0] qmax_ff, qmax_in;
   logic             bank_ff, bank_in;
   logic             have_ff, have_in;
   logic             n_last;

   // sum sweep stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_first_ff, s1_first_in;
   logic             s1_close_ff, s1_close_in;
   logic [IDX_W-1:0] s1_q_ff, s1_q_in;
   logic [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0] sum_in;

   // read data
   logic [MAG_W-1:0]  frame_rd_ff;
   logic [SUM_W-1:0]  sum_rd_ff;
   logic [PROD_W-1:0] prod_rd_ff;
   logic [PROD_W-1:0] item_rd_ff;

   // multiply sweep stages
   logic              m1_valid_ff, m1_valid_in;
   logic [IDX_W-1:0]  m1_n_ff, m1_n_in;
   logic              m2_valid_ff;
   logic [IDX_W-1:0]  m2_n_ff;
   logic              m2_keep_ff;
   logic [PROD_W-1:0] m2_base_ff;
   logic [MUL_W-1:0]  m2_prod_ff;
   logic [PROD_W-1:0] m1_base;
   logic [SUM_W-1:0]  m1_sum;
   logic [MUL_W-1:0]  m2_prod_in;
   logic              m2_ovf;
   logic [PROD_W-1:0] m2_result;

   assign busy      = (state_ff != ST_IDLE);
   assign item_data = item_rd_ff;
   assign n_last    = (n_ff == IDX_W'(FRAME_SIZE - 1));

   // pass sequencer
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      h_in        = h_ff;
      r_in        = r_ff;
      q_in        = q_ff;
      qmax_in     = qmax_ff;
      bank_in     = bank_ff;
      have_in     = have_ff;
      s1_valid_in = 1'b0;
      s1_first_in = (r_ff == '0);
      s1_close_in = (r_ff == h_ff - H_W'(1)) || n_last;
      s1_q_in     = q_ff;
      m1_valid_in = 1'b0;
      m1_n_in     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item.pop && item.entry.last) begin
               state_in = ST_SUM;
               n_in     = '0;
               h_in     = H_W'(2);
               r_in     = '0;
               q_in     = '0;
            end
         end
         ST_SUM: begin
            s1_valid_in = 1'b1;
            if (r_ff == h_ff - H_W'(1)) begin
               r_in = '0;
               q_in = q_ff + IDX_W'(1);
            end else begin
               r_in = r_ff + H_W'(1);
            end
            if (n_last) begin
               qmax_in  = q_ff;
               n_in     = '0;
               state_in = ST_SUM_DRAIN;
            end else begin
               n_in = n_ff + IDX_W'(1);
            end
         end
         ST_SUM_DRAIN: begin
            if (!s1_valid_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            m1_valid_in = 1'b1;
            if (n_last) begin
               n_in     = '0;
               state_in = ST_MUL_DRAIN;
            end else begin
               n_in = n_ff + IDX_W'(1);
            end
         end
         ST_MUL_DRAIN: begin
            if (!m1_valid_ff && !m2_valid_ff) begin
               if (h_ff == harm_top) begin
                  bank_in  = !bank_ff;
                  have_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  h_in     = h_ff + H_W'(1);
                  r_in     = '0;
                  q_in     = '0;
                  state_in = ST_SUM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bank_ff     <= 1'b0;
         have_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bank_ff     <= bank_in;
         have_ff     <= have_in;
         s1_valid_ff <= s1_valid_in;
         m1_valid_ff <= m1_valid_in;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      h_ff        <= h_in;
      r_ff        <= r_in;
      q_ff        <= q_in;
      qmax_ff     <= qmax_in;
      s1_first_ff <= s1_first_in;
      s1_close_ff <= s1_close_in;
      s1_q_ff     <= s1_q_in;
      m1_n_ff     <= m1_n_in;
   end

   // slot accumulation, restarted at the first bin of each slot
   assign sum_in = (s1_first_ff ? SUM_W'(0) : acc_ff) + SUM_W'(frame_rd_ff);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         acc_ff <= sum_in;
      end
   end

   // multiply stage: first pass starts from the frame itself, slots past
   // the last filled one count as empty
   assign m1_base    = (h_ff == H_W'(2)) ? (PROD_W'(frame_rd_ff) << FRAC_SHIFT)
                                         : prod_rd_ff;
   assign m1_sum     = (m1_n_ff <= qmax_ff) ? sum_rd_ff : '0;
   assign m2_prod_in = MUL_W'(m1_base) * MUL_W'(m1_sum);

   always_ff @(posedge clock) begin
      m2_n_ff    <= m1_n_ff;
      m2_keep_ff <= (m1_n_ff == '0);
      m2_base_ff <= m1_base;
      m2_prod_ff <= m2_prod_in;
   end

   // rescale and saturate, bin 0 keeps its starting value
   assign m2_ovf    = |m2_prod_ff[MUL_W-1:PROD_W+FRAC_SHIFT];
   assign m2_result = m2_keep_ff ? m2_base_ff
                    : (m2_ovf ? '1 : m2_prod_ff[PROD_W+FRAC_SHIFT-1:FRAC_SHIFT]);

   // input frame memory
   always_ff @(posedge clock) begin
      if (item.pop) begin
         frame_mem[item.entry.idx] <= item.entry.mag;
      end
      frame_rd_ff <= frame_mem[n_ff];
   end

   // slot sum memory
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_close_ff) begin
         sum_mem[s1_q_ff] <= sum_in;
      end
      sum_rd_ff <= sum_mem[n_ff];
   end

   // product banks: engine works on the idle bank, items read the live one
   always_ff @(posedge clock) begin
      if (m2_valid_ff) begin
         prod_mem[!bank_ff][m2_n_ff] <= m2_result;
      end
      prod_rd_ff <= prod_mem[!bank_ff][n_ff];
      item_rd_ff <= have_ff ? prod_mem[bank_ff][item.entry.idx] : '0;
   end

endmodule

// ===== design/hps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_back: back end
// Takes queued items when the engine is free, writes each bin into the frame
// store, fetches the matching product bin and presents it on the result
// channel. Holds the harmonic setting register.
// ----------------------------------------------------------------------------
module hps_back import hps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  hps_entry_type     head_entry,
   output logic              pop,
   input  logic              csr_wr_en,
   input  logic [HARM_W-1:0] csr_wr_data,
   hps_rsp_if.source         rsp_ch
);

   logic [HARM_W-1:0] harmonics_max_ff;
   logic [H_W-1:0]    harm_top;
   hps_item_type      item;
   logic [PROD_W-1:0] item_data;
   logic              busy;

   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic              pend_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PROD_W-1:0] rsp_value_ff;
   logic [BIN_W-1:0]  rsp_idx_ff;
   logic              rsp_last_ff;

   // harmonic setting
   always_ff @(posedge clock) begin
      if (reset) begin
         harmonics_max_ff <= HARM_W'(HARM_RESET);
      end else if (csr_wr_en) begin
         harmonics_max_ff <= csr_wr_data;
      end
   end

   // clip the setting to the supported range
   always_comb begin
      if (32'(harmonics_max_ff) < HARM_MIN) begin
         harm_top = H_W'(HARM_MIN);
      end else if (32'(harmonics_max_ff) > MAX_HARMONICS) begin
         harm_top = H_W'(MAX_HARMONICS);
      end else begin
         harm_top = H_W'(harmonics_max_ff);
      end
   end

   // take the next item only with the engine idle and the result slot free
   assign pop        = head_valid && !busy && !pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign item.pop   = pop;
   assign item.entry = head_entry;

   hps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .harm_top  (harm_top),
      .item      (item),
      .item_data (item_data),
      .busy      (busy)
   );

   // pending read and result register
   always_comb begin
      pend_in      = pop;
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pend_idx_ff  <= head_entry.idx;
         pend_last_ff <= head_entry.last;
      end
      if (pend_ff) begin
         rsp_value_ff <= item_data;
         rsp_idx_ff   <= BIN_W'(pend_idx_ff);
         rsp_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.product_value = rsp_value_ff;
   assign rsp_ch.bin_index     = rsp_idx_ff;
   assign rsp_ch.frame_last    = rsp_last_ff;

endmodule

// ===== design/harmonic_product_spectrum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_product_spectrum: frame-based harmonic product spectrum
// Usage:
//   req_ch takes one Q8.8 bin magnitude per item, bins in index order.
//   rsp_ch returns one item per input item: the harmonic product of the
//   previous frame at the same bin (Q16.16, saturated), its bin index and
//   a flag on the last bin. The first frame after reset returns zeros.
//   csr_wr_en/csr_wr_data set the highest harmonic (clipped to 2..16);
//   write it only while no items are in flight.
// Flow:
//   an accepted item passes the queue, a pending read stage and the result
//   register; the back end takes no new item while a read is pending.
//   After the last bin of a frame the engine runs (H-1) passes (a sum sweep
//   and a multiply sweep, one bin per cycle each), during which the back
//   end takes no items and only the two queue entries are taken.
// Reset clears the bin position, the queue, the bank select and the
//   result register; product memories need no clearing pass.
// A stalled receiver holds the result register, the queue then fills and
//   req_ch.ready drops.
// ----------------------------------------------------------------------------
module harmonic_product_spectrum import hps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   hps_req_if.sink           req_ch,
   hps_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [HARM_W-1:0] csr_wr_data
);

   logic          push;
   hps_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   hps_entry_type head_entry;

   // accept and classify items
   hps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   hps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // frame store, product engine and result register
   hps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ch      (rsp_ch)
   );

endmodule
